FILE: rtl/scu_pkg.sv
`default_nettype none

package scu_pkg;

    // field widths
    localparam int CoordW = 32;
    localparam int RadW   = 31;
    localparam int DiffW  = CoordW + 1;
    localparam int SqW    = 2 * DiffW;
    localparam int RootW  = 34;
    localparam int SqrtSteps = RootW;
    localparam int RemW   = RootW + 1;
    localparam int VecW   = RootW + 2;

    // query codes
    typedef enum logic [1:0] {
        OP_SPHERE  = 2'd0,
        OP_POINT   = 2'd1,
        OP_SURFACE = 2'd2
    } scu_op_e;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [CoordW-1:0] center_x;
        logic signed [CoordW-1:0] center_y;
        logic signed [CoordW-1:0] center_z;
        logic [RadW-1:0]          radius_a;
        logic signed [CoordW-1:0] other_x;
        logic signed [CoordW-1:0] other_y;
        logic signed [CoordW-1:0] other_z;
        logic [RadW-1:0]          radius_b;
    } scu_query_t;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] vec_x;
        logic signed [CoordW-1:0] vec_y;
        logic signed [CoordW-1:0] vec_z;
        logic                     degenerate;
        logic                     saturated;
    } scu_result_t;

    // decoded query kind, all clear for the unused code
    typedef struct packed {
        logic sphere;
        logic point;
        logic surface;
    } scu_kind_t;

    // classified command handed from front to back
    typedef struct packed {
        scu_kind_t                   kind;
        logic [2:0][CoordW-1:0]      c;
        logic [2:0][DiffW-1:0]       d;
        logic [RadW-1:0]             ra;
        logic [RadW-1:0]             rb;
    } scu_cmd_t;

    // command plus distance results, carried through the divider
    typedef struct packed {
        scu_cmd_t         cmd;
        logic [RootW-1:0] len;
        logic [RootW-1:0] mag;
        logic             flip;
        logic             hit;
        logic             deg;
    } scu_meta_t;

    function automatic logic [DiffW-1:0] abs_diff(input logic [DiffW-1:0] d);
        return d[DiffW-1] ? DiffW'(~d + 1'b1) : d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scu_if.sv
`default_nettype none

interface scu_query_if;
    import scu_pkg::*;
    logic       valid;
    logic       ready;
    scu_query_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface scu_result_if;
    import scu_pkg::*;
    logic        valid;
    logic        ready;
    scu_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sphere_collision_unit.sv
// channel  | dir | payload                                         | transfer
// ---------+-----+-------------------------------------------------+-------------------
// query    | in  | opcode, centre xyz, radius_a, other xyz, radius_b | valid & ready
// result   | out | hit, vec xyz, degenerate, saturated              | valid & ready
//
// one query per cycle sustained while result.ready stays high
// the pipe runs through front, queue, squares, sum, 34 square root stages, separation,
// FRAC_BITS + 1 divider stages, scale and output register
// rst_n clears all valid bits and queue pointers; payload registers are not reset
// a stalled result freezes the back pipe; the front register and the 4-entry queue keep
// taking queries until they are full, then query.ready drops
`default_nettype none

module sphere_collision_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    scu_query_if.sink    query,
    scu_result_if.source result
);
    import scu_pkg::*;

    logic     f_valid;
    logic     f_ready;
    scu_cmd_t f_cmd;
    logic     b_valid;
    logic     b_ready;
    scu_cmd_t b_cmd;

    // decode and difference
    scu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // decoupling queue
    scu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    // distance, normalize, scale
    scu_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd       (b_cmd),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: rtl/scu_front.sv
`default_nettype none

module scu_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    scu_query_if.sink       query,
    output logic            cmd_valid,
    input  wire logic       cmd_ready,
    output scu_pkg::scu_cmd_t cmd
);
    import scu_pkg::*;

    logic     f_valid_reg;
    logic     f_valid_next;
    scu_cmd_t f_cmd_reg;
    scu_cmd_t f_cmd_next;
    logic     take;

    // hold one classified command, refill on the cycle it moves on
    assign query.ready = !f_valid_reg || cmd_ready;
    assign take        = query.valid && query.ready;
    assign cmd_valid   = f_valid_reg;
    assign cmd         = f_cmd_reg;

    // decode the query code and form the per-axis differences
    always_comb
    begin
        f_cmd_next      = '0;
        case (scu_op_e'(query.data.opcode))
            OP_SPHERE:  f_cmd_next.kind.sphere  = 1'b1;
            OP_POINT:   f_cmd_next.kind.point   = 1'b1;
            OP_SURFACE: f_cmd_next.kind.surface = 1'b1;
            default:    f_cmd_next.kind         = '0;
        endcase
        f_cmd_next.c[0] = query.data.center_x;
        f_cmd_next.c[1] = query.data.center_y;
        f_cmd_next.c[2] = query.data.center_z;
        f_cmd_next.d[0] = DiffW'(query.data.other_x) - DiffW'(query.data.center_x);
        f_cmd_next.d[1] = DiffW'(query.data.other_y) - DiffW'(query.data.center_y);
        f_cmd_next.d[2] = DiffW'(query.data.other_z) - DiffW'(query.data.center_z);
        f_cmd_next.ra   = query.data.radius_a;
        f_cmd_next.rb   = query.data.radius_b;
    end

    always_comb
    begin
        if (take)
            f_valid_next = 1'b1;
        else if (cmd_ready)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            f_cmd_reg <= f_cmd_next;
    end

endmodule

`default_nettype wire

FILE: rtl/scu_queue.sv
`default_nettype none

module scu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  scu_pkg::scu_cmd_t in_cmd,
    output logic              out_valid,
    input  wire logic         out_ready,
    output scu_pkg::scu_cmd_t out_cmd
);
    import scu_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    scu_cmd_t        mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg != CntW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        case ({push, pop})
            2'b10:   count_next = CntW'(count_reg + 1'b1);
            2'b01:   count_next = CntW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

`default_nettype wire

FILE: rtl/scu_back.sv
`default_nettype none

module scu_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    output logic              cmd_ready,
    input  scu_pkg::scu_cmd_t cmd,
    scu_result_if.source      result
);
    import scu_pkg::*;

    localparam int QW       = FRAC_BITS + 1;
    localparam int DivSteps = FRAC_BITS + 1;
    localparam int ProdW    = QW + RootW;

    logic en;

    // the whole pipe advances unless a finished result is held
    logic        out_valid_reg;
    scu_result_t out_data_reg;
    assign en           = !out_valid_reg || result.ready;
    assign cmd_ready    = en;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // squares of the differences and of radius_a
    logic                   sq_valid_reg;
    scu_cmd_t               sq_cmd_reg;
    logic [2:0][SqW-1:0]    sq_reg;
    logic [2:0][SqW-1:0]    sq_next;
    logic [2*RadW-1:0]      sq_ra2_reg;
    logic [2*RadW-1:0]      sq_ra2_next;

    always_comb
    begin
        logic [DiffW-1:0] m;
        for (int k = 0; k < 3; k++)
        begin
            m          = abs_diff(cmd.d[k]);
            sq_next[k] = SqW'(m) * SqW'(m);
        end
        sq_ra2_next = (2*RadW)'(cmd.ra) * (2*RadW)'(cmd.ra);
    end

    // squared distance
    logic              sum_valid_reg;
    scu_cmd_t          sum_cmd_reg;
    logic [SqW-1:0]    sum_reg;
    logic [2*RadW-1:0] sum_ra2_reg;

    // square root, two radicand bits per stage
    logic             rt_valid_reg [SqrtSteps];
    scu_cmd_t         rt_cmd_reg   [SqrtSteps];
    logic [SqW-1:0]   rt_s_reg     [SqrtSteps];
    logic [RemW-1:0]  rt_rem_reg   [SqrtSteps];
    logic [RootW-1:0] rt_root_reg  [SqrtSteps];
    logic             rt_hit1_reg  [SqrtSteps];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg  <= cmd_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_cmd_reg  <= cmd;
            sq_reg      <= sq_next;
            sq_ra2_reg  <= sq_ra2_next;
            sum_cmd_reg <= sq_cmd_reg;
            sum_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sum_ra2_reg <= sq_ra2_reg;
        end
    end

    for (genvar i = 0; i < SqrtSteps; i++)
    begin : g_root
        logic             in_valid;
        scu_cmd_t         in_cmd;
        logic [SqW-1:0]   in_s;
        logic [RemW-1:0]  in_rem;
        logic [RootW-1:0] in_root;
        logic             in_hit1;
        logic [SqW+1:0]   s_pad;
        logic [RemW+1:0]  cand;
        logic [RemW+1:0]  trial;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign in_valid = sum_valid_reg;
            assign in_cmd   = sum_cmd_reg;
            assign in_s     = sum_reg;
            assign in_rem   = '0;
            assign in_root  = '0;
            assign in_hit1  = SqW'(sum_ra2_reg) > sum_reg;
        end
        else
        begin : g_next
            assign in_valid = rt_valid_reg[i-1];
            assign in_cmd   = rt_cmd_reg[i-1];
            assign in_s     = rt_s_reg[i-1];
            assign in_rem   = rt_rem_reg[i-1];
            assign in_root  = rt_root_reg[i-1];
            assign in_hit1  = rt_hit1_reg[i-1];
        end

        // bring down the next bit pair and try root*4+1
        assign s_pad = {2'b00, in_s};
        assign cand  = {in_rem, s_pad[SqW+1-2*i -: 2]};
        assign trial = (RemW+2)'({in_root, 2'b01});
        assign ge    = cand >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_valid_reg[i] <= 1'b0;
            else if (en)
                rt_valid_reg[i] <= in_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_cmd_reg[i]  <= in_cmd;
                rt_s_reg[i]    <= in_s;
                rt_rem_reg[i]  <= RemW'(ge ? cand - trial : cand);
                rt_root_reg[i] <= {in_root[RootW-2:0], ge};
                rt_hit1_reg[i] <= in_hit1;
            end
        end
    end

    // separation, hit and the scale magnitude
    logic      sp_valid_reg;
    scu_meta_t sp_meta_reg;
    scu_meta_t sp_meta_next;

    always_comb
    begin
        logic [RootW-1:0] len;
        logic [RootW-1:0] rsum;
        logic             hit0;
        logic [RootW-1:0] sep_mag;
        scu_cmd_t         c;
        c       = rt_cmd_reg[SqrtSteps-1];
        len     = rt_root_reg[SqrtSteps-1];
        rsum    = RootW'(c.ra) + RootW'(c.rb);
        hit0    = len < rsum;
        sep_mag = hit0 ? rsum - len : len - rsum;
        sp_meta_next.cmd  = c;
        sp_meta_next.len  = len;
        sp_meta_next.mag  = c.kind.sphere ? sep_mag : RootW'(c.ra);
        sp_meta_next.flip = c.kind.sphere && hit0;
        sp_meta_next.hit  = (c.kind.sphere && hit0) ||
                            (c.kind.point && rt_hit1_reg[SqrtSteps-1]);
        sp_meta_next.deg  = (c.kind.sphere || c.kind.surface) && (len == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_valid_reg <= 1'b0;
        else if (en)
            sp_valid_reg <= rt_valid_reg[SqrtSteps-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sp_meta_reg <= sp_meta_next;
    end

    // restoring division of |d| << FRAC_BITS by the length, one quotient bit per stage
    logic                  dv_valid_reg [DivSteps];
    scu_meta_t             dv_meta_reg  [DivSteps];
    logic [2:0][RootW-1:0] dv_rem_reg   [DivSteps];
    logic [2:0][QW-1:0]    dv_q_reg     [DivSteps];

    for (genvar j = 0; j < DivSteps; j++)
    begin : g_div
        logic                  in_valid;
        scu_meta_t             in_meta;
        logic [2:0][RootW-1:0] in_rem;
        logic [2:0][QW-1:0]    in_q;
        logic [2:0][RootW-1:0] rem_next;
        logic [2:0][QW-1:0]    q_next;

        if (j == 0)
        begin : g_first
            assign in_valid = sp_valid_reg;
            assign in_meta  = sp_meta_reg;
            assign in_rem   = '0;
            assign in_q     = '0;
        end
        else
        begin : g_next
            assign in_valid = dv_valid_reg[j-1];
            assign in_meta  = dv_meta_reg[j-1];
            assign in_rem   = dv_rem_reg[j-1];
            assign in_q     = dv_q_reg[j-1];
        end

        always_comb
        begin
            logic [RootW:0] r;
            logic           ge;
            for (int k = 0; k < 3; k++)
            begin
                if (j == 0)
                    r = (RootW+1)'(abs_diff(in_meta.cmd.d[k]));
                else
                    r = {in_rem[k], 1'b0};
                ge          = r >= (RootW+1)'(in_meta.len);
                rem_next[k] = RootW'(ge ? r - (RootW+1)'(in_meta.len) : r);
                q_next[k]   = {in_q[k][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (en)
                dv_valid_reg[j] <= in_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_meta_reg[j] <= in_meta;
                dv_rem_reg[j]  <= rem_next;
                dv_q_reg[j]    <= q_next;
            end
        end
    end

    // scale the unit vector by the magnitude
    logic                  mu_valid_reg;
    scu_meta_t             mu_meta_reg;
    logic [2:0][RootW-1:0] mu_p_reg;
    logic [2:0][RootW-1:0] mu_p_next;
    logic [2:0]            mu_neg_reg;
    logic [2:0]            mu_neg_next;

    always_comb
    begin
        logic [ProdW-1:0] prod;
        for (int k = 0; k < 3; k++)
        begin
            prod = ProdW'(dv_q_reg[DivSteps-1][k]) * ProdW'(dv_meta_reg[DivSteps-1].mag);
            mu_p_next[k]   = RootW'(prod >> FRAC_BITS);
            mu_neg_next[k] = dv_meta_reg[DivSteps-1].cmd.d[k][DiffW-1] ^
                             dv_meta_reg[DivSteps-1].flip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_valid_reg <= 1'b0;
        else if (en)
            mu_valid_reg <= dv_valid_reg[DivSteps-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mu_meta_reg <= dv_meta_reg[DivSteps-1];
            mu_p_reg    <= mu_p_next;
            mu_neg_reg  <= mu_neg_next;
        end
    end

    // select per query, add the centre for a surface query, clamp to 32 bits
    scu_result_t           out_data_next;
    logic [2:0][CoordW-1:0] vec;

    always_comb
    begin
        logic signed [VecW-1:0] ps;
        logic signed [VecW-1:0] v;
        logic                   hi;
        logic                   lo;
        logic                   sat;
        sat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ps = VecW'(mu_p_reg[k]);
            if (mu_neg_reg[k])
                ps = -ps;
            if (mu_meta_reg.deg)
                ps = '0;
            if (mu_meta_reg.cmd.kind.point)
                v = VecW'($signed(mu_meta_reg.cmd.d[k]));
            else if (mu_meta_reg.cmd.kind.sphere)
                v = ps;
            else if (mu_meta_reg.cmd.kind.surface)
                v = VecW'($signed(mu_meta_reg.cmd.c[k])) + ps;
            else
                v = '0;
            hi = v > 36'sd2147483647;
            lo = v < -36'sd2147483648;
            sat = sat || hi || lo;
            if (hi)
                vec[k] = 32'h7FFF_FFFF;
            else if (lo)
                vec[k] = 32'h8000_0000;
            else
                vec[k] = v[CoordW-1:0];
        end
        out_data_next.hit        = mu_meta_reg.hit;
        out_data_next.vec_x      = vec[0];
        out_data_next.vec_y      = vec[1];
        out_data_next.vec_z      = vec[2];
        out_data_next.degenerate = mu_meta_reg.deg;
        out_data_next.saturated  = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= mu_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/scu_checker.sv
`default_nettype none

module scu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_degenerate,
    input wire logic        out_saturated,
    input wire logic        out_hit,
    input wire logic [31:0] out_vec_x,
    input wire logic [31:0] out_vec_y,
    input wire logic [31:0] out_vec_z
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({out_hit, out_vec_x, out_vec_y, out_vec_z, out_degenerate, out_saturated}))
        else $error("result changed while stalled");

    // a zero length never leads to clamping
    a_deg_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_degenerate |-> !out_saturated)
        else $error("degenerate result flagged saturated");

    // clamping leaves some component at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_saturated |->
        out_vec_x == 32'h7FFF_FFFF || out_vec_x == 32'h8000_0000 ||
        out_vec_y == 32'h7FFF_FFFF || out_vec_y == 32'h8000_0000 ||
        out_vec_z == 32'h7FFF_FFFF || out_vec_z == 32'h8000_0000)
        else $error("saturated without a clamped component");

    // nothing leaves the unit right out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind sphere_collision_unit scu_checker u_scu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_degenerate (result.data.degenerate),
    .out_saturated  (result.data.saturated),
    .out_hit        (result.data.hit),
    .out_vec_x      (result.data.vec_x),
    .out_vec_y      (result.data.vec_y),
    .out_vec_z      (result.data.vec_z)
);

`default_nettype wire

FILE: tb/sphere_collision_checker.sv
`default_nettype none

module sphere_collision_checker
    import scu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    scu_query_if      query,
    scu_result_if     result,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    scu_result_t expected_results[$];

    // integer square root of a sum of squares, wide enough for 3 * 2^66
    function automatic logic [33:0] root_floor(input logic [67:0] s);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            if ({34'd0, c} * {34'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    // unit direction component scaled by a magnitude, signed
    function automatic logic signed [71:0] dir_scaled(input logic signed [33:0] d,
                                                      input logic [33:0] len,
                                                      input logic [33:0] m);
        logic [71:0] q;
        logic [71:0] p;
        q = ({38'd0, (d < 0) ? 34'(-d) : 34'(d)} << FRAC_BITS) / {38'd0, len};
        p = (q * {38'd0, m}) >> FRAC_BITS;
        return (d < 0) ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [31:0] clamp_word(input logic signed [71:0] v,
                                               inout logic sat);
        if (v > 72'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -72'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // collision query prediction
    function automatic scu_result_t collide(input scu_query_t q);
        scu_result_t r;
        logic signed [33:0] c[3];
        logic signed [33:0] d[3];
        logic signed [71:0] v[3];
        logic [67:0] s;
        logic [33:0] len;
        logic [33:0] rsum;
        logic signed [35:0] sep;
        logic [33:0] sepm;
        logic sat;
        c[0] = q.center_x; c[1] = q.center_y; c[2] = q.center_z;
        d[0] = 34'(q.other_x) - c[0];
        d[1] = 34'(q.other_y) - c[1];
        d[2] = 34'(q.other_z) - c[2];
        s = '0;
        // widen before squaring so the full square is kept
        for (int k = 0; k < 3; k++)
            s += 68'(d[k]) * 68'(d[k]);
        len = root_floor(s);
        r = '0;
        sat = 1'b0;
        for (int k = 0; k < 3; k++)
            v[k] = '0;
        case (q.opcode)
            OP_SPHERE:
            begin
                rsum = 34'(q.radius_a) + 34'(q.radius_b);
                sep = $signed({2'b0, len}) - $signed({2'b0, rsum});
                sepm = (sep < 0) ? 34'(-sep) : 34'(sep);
                r.hit = len < rsum;
                if (len == 0)
                    r.degenerate = 1'b1;
                else
                    for (int k = 0; k < 3; k++)
                        v[k] = (sep < 0) ? -dir_scaled(d[k], len, sepm)
                                         : dir_scaled(d[k], len, sepm);
            end
            OP_POINT:
            begin
                r.hit = 68'(q.radius_a) * 68'(q.radius_a) > s;
                for (int k = 0; k < 3; k++)
                    v[k] = d[k];
            end
            OP_SURFACE:
            begin
                r.degenerate = len == 0;
                for (int k = 0; k < 3; k++)
                    v[k] = c[k] + ((len == 0) ? 72'sd0
                                   : dir_scaled(d[k], len, 34'(q.radius_a)));
            end
            default: ;
        endcase
        r.vec_x = clamp_word(v[0], sat);
        r.vec_y = clamp_word(v[1], sat);
        r.vec_z = clamp_word(v[2], sat);
        r.saturated = sat;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // predict on query transfer, compare on result transfer
    always @(posedge clk or negedge rst_n)
    begin
        scu_result_t e;
        scu_result_t a;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (query.valid && query.ready)
                expected_results.push_back(collide(query.data));
            if (result.valid && result.ready)
            begin
                a = result.data;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (a !== e)
                    begin
                        if (a.hit !== e.hit)
                            $error("hit exp %0d got %0d", e.hit, a.hit);
                        if (a.vec_x !== e.vec_x)
                            $error("vec_x exp %0d got %0d", e.vec_x, a.vec_x);
                        if (a.vec_y !== e.vec_y)
                            $error("vec_y exp %0d got %0d", e.vec_y, a.vec_y);
                        if (a.vec_z !== e.vec_z)
                            $error("vec_z exp %0d got %0d", e.vec_z, a.vec_z);
                        if (a.degenerate !== e.degenerate)
                            $error("degenerate exp %0d got %0d", e.degenerate,
                                   a.degenerate);
                        if (a.saturated !== e.saturated)
                            $error("saturated exp %0d got %0d", e.saturated,
                                   a.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sphere_collision_unit_tb.sv
`default_nettype none

module sphere_collision_unit_tb;
    import scu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY = FRAC_BITS + 42;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1400;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_off;
    logic done;
    int   quiet_cycles;

    scu_query_if  query();
    scu_result_if result();

    sphere_collision_unit #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .result (result)
    );

    sphere_collision_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .query         (query),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // random coordinate: mostly small values, sometimes any word or an extreme
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2, 3: return $urandom();
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [30:0] pick_radius();
        case ($urandom_range(0, 7))
            0: return 31'h7fffffff;
            1: return '0;
            2: return 31'($urandom());
            default: return 31'($urandom_range(0, 1500000));
        endcase
    endfunction

    function automatic scu_query_t random_query();
        scu_query_t q;
        q.opcode   = 2'($urandom_range(0, 3));
        q.center_x = pick_coord();
        q.center_y = pick_coord();
        q.center_z = pick_coord();
        q.radius_a = pick_radius();
        q.radius_b = pick_radius();
        if ($urandom_range(0, 7) == 0)
        begin
            q.other_x = q.center_x;
            q.other_y = q.center_y;
            q.other_z = q.center_z;
        end
        else
        begin
            q.other_x = ($urandom_range(0, 1)) ? pick_coord()
                                               : q.center_x + 32'($urandom_range(0, 300000));
            q.other_y = pick_coord();
            q.other_z = pick_coord();
        end
        return q;
    endfunction

    task automatic send_query(input scu_query_t q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            query.valid <= 1'b0;
            @(posedge clk);
        end
        query.valid <= 1'b1;
        query.data  <= q;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
    endtask

    task automatic directed_queries();
        scu_query_t q;
        scu_op_e op;
        op = OP_SPHERE;
        for (int k = 0; k < 4; k++)
        begin
            // coincident centres: degenerate for the sphere and surface codes
            q = '0;
            q.opcode = 2'(k);
            q.radius_a = 31'd65536;
            q.radius_b = (k == 0) ? 31'd0 : 31'd3;
            send_query(q);
            // opposite extreme corners: widest distance, saturation for a point query
            q.center_x = 32'h80000000; q.center_y = 32'h80000000;
            q.center_z = 32'h80000000;
            q.other_x = 32'h7fffffff; q.other_y = 32'h7fffffff;
            q.other_z = 32'h7fffffff;
            q.radius_a = 31'h7fffffff; q.radius_b = 31'h7fffffff;
            send_query(q);
            // touching spheres and a point on the boundary
            q = '0;
            q.opcode = 2'(k);
            q.other_x = 32'sd196608;
            q.radius_a = 31'd131072; q.radius_b = 31'd65536;
            send_query(q);
            q.other_y = -32'sd65536;
            q.other_z = 32'sd1;
            q.radius_a = 31'h7fffffff;
            send_query(q);
            q.center_x = 32'h7fffffff; q.other_x = 32'h80000000;
            q.radius_a = 31'd1; q.radius_b = 31'h7fffffff;
            send_query(q);
        end
        q = '0;
        q.opcode = op;
        q.other_x = -32'sd3; q.other_y = 32'sd4;
        q.radius_a = 31'd2; q.radius_b = 31'd2;
        send_query(q);
    endtask

    // receiver side: random stall, or a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((query.valid && query.ready) || (result.valid && result.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold-off while queries keep coming
    initial
    begin
        hold_off = 1'b0;
        wait (done === 1'b1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        done = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        query.valid = 1'b0;
        query.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_queries();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                3: begin send_idle_pct = 34; recv_stall_pct = 34; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; done <= 1'b1; end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
                send_query(random_query());
        end
        query.valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
